>>> sv/mbsp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI byte stream parser package
// Shared types and constants for the front queue, the parse engine and the
// result queue.
// ----------------------------------------------------------------------------
package mbsp_pkg;

	localparam int IQ_DEPTH = 4;
	localparam int IQ_AW    = $clog2(IQ_DEPTH);
	localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);

	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	localparam logic [6:0] CC_MODE_MIN = 7'd120;

	typedef enum logic [3:0] {
		K_NOTEOFF = 4'd0,
		K_NOTEON  = 4'd1,
		K_POLYAT  = 4'd2,
		K_CC      = 4'd3,
		K_PROG    = 4'd4,
		K_CHANAT  = 4'd5,
		K_BEND    = 4'd6,
		K_QFRAME  = 4'd7,
		K_SONGPOS = 4'd8,
		K_SONGSEL = 4'd9,
		K_SXSTART = 4'd10,
		K_SXDATA  = 4'd11,
		K_SXEND   = 4'd12
	} msg_kind_t;

	typedef enum logic [2:0] {
		CLS_DATA,
		CLS_VOICE,
		CLS_SX_START,
		CLS_QFRAME,
		CLS_SONGPOS,
		CLS_SONGSEL,
		CLS_STOP
	} byte_cls_t;

	typedef struct packed {
		byte_cls_t  cls;
		logic [6:0] payload;
	} cls_item_t;

	typedef struct packed {
		msg_kind_t  kind;
		logic [3:0] channel;
		logic [6:0] first_data;
		logic [6:0] second_data;
		logic       last;
	} result_t;

endpackage

>>> sv/mbsp_front.sv
// ----------------------------------------------------------------------------
// MIDI parser front queue
// Accepts received bytes, drops real-time bytes and queues the others with
// their class for the parse engine.
// ----------------------------------------------------------------------------
module mbsp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [7:0]          rx_byte,
	output logic                full,
	input  logic                head_pop,
	output logic                head_valid,
	output mbsp_pkg::cls_item_t head
);

	mbsp_pkg::cls_item_t            mem_q [mbsp_pkg::IQ_DEPTH];
	logic [mbsp_pkg::IQ_AW-1:0]     wr_ptr_q;
	logic [mbsp_pkg::IQ_AW-1:0]     rd_ptr_q;
	logic [mbsp_pkg::IQ_CW-1:0]     count_q;
	mbsp_pkg::cls_item_t            item;
	logic                           rt_byte;
	logic                           wr_en;
	logic                           rd_en;

	assign full       = (count_q == mbsp_pkg::IQ_CW'(mbsp_pkg::IQ_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign rt_byte    = (rx_byte[7:3] == 5'b11111);
	assign wr_en      = push && !full && !rt_byte;
	assign rd_en      = head_pop && head_valid;

	always_comb begin
		item.payload = rx_byte[6:0];
		if (!rx_byte[7]) begin
			item.cls = mbsp_pkg::CLS_DATA;
		end else if (rx_byte[6:4] != 3'b111) begin
			item.cls = mbsp_pkg::CLS_VOICE;
		end else begin
			case (rx_byte[3:0])
				4'h0:    item.cls = mbsp_pkg::CLS_SX_START;
				4'h1:    item.cls = mbsp_pkg::CLS_QFRAME;
				4'h2:    item.cls = mbsp_pkg::CLS_SONGPOS;
				4'h3:    item.cls = mbsp_pkg::CLS_SONGSEL;
				default: item.cls = mbsp_pkg::CLS_STOP;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == mbsp_pkg::IQ_AW'(mbsp_pkg::IQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == mbsp_pkg::IQ_AW'(mbsp_pkg::IQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sv/mbsp_back.sv
// ----------------------------------------------------------------------------
// MIDI parser engine
// Runs the running-status parse on classified bytes and writes decoded
// messages into the result queue.
// ----------------------------------------------------------------------------
module mbsp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  mbsp_pkg::cls_item_t head,
	output logic                head_pop,
	input  logic                res_full,
	output logic                res_push,
	output mbsp_pkg::result_t   res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ONE,
		ST_FIRST,
		ST_SECOND,
		ST_SYSEX
	} state_t;

	state_t              state_q;
	state_t              state_nxt;
	logic                rs_valid_q;
	logic                rs_valid_nxt;
	logic [3:0]          rs_chan_q;
	logic [3:0]          rs_chan_nxt;
	mbsp_pkg::msg_kind_t pend_kind_q;
	mbsp_pkg::msg_kind_t pend_kind_nxt;
	logic [6:0]          held_q;
	logic [6:0]          held_nxt;
	logic                emit;
	logic                split;
	logic                go;
	logic [3:0]          chan;
	logic [2:0]          hi;

	assign chan = rs_valid_q ? rs_chan_q : 4'd0;
	assign hi   = head.payload[6:4];
	assign go   = head_valid && !res_full;

	always_comb begin
		state_nxt     = state_q;
		rs_valid_nxt  = rs_valid_q;
		rs_chan_nxt   = rs_chan_q;
		pend_kind_nxt = pend_kind_q;
		held_nxt      = held_q;
		emit          = 1'b0;
		split         = 1'b0;
		res           = '{kind: mbsp_pkg::K_NOTEOFF, channel: 4'd0, first_data: 7'd0,
		                  second_data: 7'd0, last: 1'b1};
		if (head.cls == mbsp_pkg::CLS_DATA) begin
			case (state_q)
				ST_ONE: begin
					emit            = 1'b1;
					res.kind        = pend_kind_q;
					res.channel     = chan;
					res.first_data  = head.payload;
					state_nxt       = rs_valid_q ? ST_ONE : ST_IDLE;
				end
				ST_FIRST: begin
					held_nxt  = head.payload;
					state_nxt = ST_SECOND;
				end
				ST_SECOND: begin
					state_nxt       = rs_valid_q ? ST_FIRST : ST_IDLE;
					emit            = !(pend_kind_q == mbsp_pkg::K_CC &&
					                    held_q >= mbsp_pkg::CC_MODE_MIN);
					res.kind        = (pend_kind_q == mbsp_pkg::K_NOTEON &&
					                   head.payload == 7'd0) ?
					                  mbsp_pkg::K_NOTEOFF : pend_kind_q;
					res.channel     = chan;
					res.first_data  = held_q;
					res.second_data = head.payload;
				end
				ST_SYSEX: begin
					emit           = 1'b1;
					res.kind       = mbsp_pkg::K_SXDATA;
					res.first_data = head.payload;
				end
				default: begin
					state_nxt = ST_IDLE;
				end
			endcase
		end else begin
			if (state_q == ST_SYSEX) begin
				emit     = 1'b1;
				res.kind = mbsp_pkg::K_SXEND;
				if (head.cls == mbsp_pkg::CLS_SX_START) begin
					split     = 1'b1;
					res.last  = 1'b0;
					state_nxt = ST_IDLE;
				end
			end
			if (!split) begin
				case (head.cls)
					mbsp_pkg::CLS_VOICE: begin
						rs_valid_nxt  = 1'b1;
						rs_chan_nxt   = head.payload[3:0];
						pend_kind_nxt = mbsp_pkg::msg_kind_t'({1'b0, hi});
						state_nxt     = ({1'b0, hi} == mbsp_pkg::K_PROG ||
						                 {1'b0, hi} == mbsp_pkg::K_CHANAT) ?
						                ST_ONE : ST_FIRST;
					end
					mbsp_pkg::CLS_SX_START: begin
						rs_valid_nxt = 1'b0;
						emit         = 1'b1;
						res.kind     = mbsp_pkg::K_SXSTART;
						state_nxt    = ST_SYSEX;
					end
					mbsp_pkg::CLS_QFRAME: begin
						rs_valid_nxt  = 1'b0;
						pend_kind_nxt = mbsp_pkg::K_QFRAME;
						state_nxt     = ST_ONE;
					end
					mbsp_pkg::CLS_SONGPOS: begin
						rs_valid_nxt  = 1'b0;
						pend_kind_nxt = mbsp_pkg::K_SONGPOS;
						state_nxt     = ST_FIRST;
					end
					mbsp_pkg::CLS_SONGSEL: begin
						rs_valid_nxt  = 1'b0;
						pend_kind_nxt = mbsp_pkg::K_SONGSEL;
						state_nxt     = ST_ONE;
					end
					default: begin
						rs_valid_nxt = 1'b0;
						state_nxt    = ST_IDLE;
					end
				endcase
			end
		end
	end

	assign head_pop = go && !split;
	assign res_push = go && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rs_valid_q  <= 1'b0;
			rs_chan_q   <= 4'd0;
			pend_kind_q <= mbsp_pkg::K_NOTEOFF;
			held_q      <= 7'd0;
		end else if (go) begin
			state_q     <= state_nxt;
			rs_valid_q  <= rs_valid_nxt;
			rs_chan_q   <= rs_chan_nxt;
			pend_kind_q <= pend_kind_nxt;
			held_q      <= held_nxt;
		end
	end

`ifndef SYNTH
	// A sysex end that leaves its status byte queued is followed by an idle parser.
	a_split_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !head_pop) |=> (state_q == ST_IDLE))
		else $error("split transfer did not leave the parser idle");

	// Only a status byte arriving inside a sysex holds the queue head.
	a_split_only_sysex: assert property (@(posedge clk) disable iff (!arst_n)
		(go && !head_pop) |-> (state_q == ST_SYSEX && head.cls == mbsp_pkg::CLS_SX_START))
		else $error("queue head held outside a sysex restart");

	// A held result is never the last one of its byte.
	a_split_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !head_pop) |-> !res.last)
		else $error("first of two results marked as last");
`endif

endmodule

>>> sv/mbsp_outq.sv
// ----------------------------------------------------------------------------
// MIDI parser result queue
// Holds decoded messages until the consumer takes them.
// ----------------------------------------------------------------------------
module mbsp_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_push,
	input  mbsp_pkg::result_t wr_data,
	output logic              wr_full,
	input  logic              rd_pop,
	output logic              rd_empty,
	output mbsp_pkg::result_t rd_data
);

	mbsp_pkg::result_t          mem_q [mbsp_pkg::OQ_DEPTH];
	logic [mbsp_pkg::OQ_AW-1:0] wr_ptr_q;
	logic [mbsp_pkg::OQ_AW-1:0] rd_ptr_q;
	logic [mbsp_pkg::OQ_CW-1:0] count_q;
	logic                       wr_en;
	logic                       rd_en;

	assign wr_full  = (count_q == mbsp_pkg::OQ_CW'(mbsp_pkg::OQ_DEPTH));
	assign rd_empty = (count_q == '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign wr_en    = wr_push && !wr_full;
	assign rd_en    = rd_pop && !rd_empty;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == mbsp_pkg::OQ_AW'(mbsp_pkg::OQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == mbsp_pkg::OQ_AW'(mbsp_pkg::OQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	// The engine only writes when there is room.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_push |-> !wr_full)
		else $error("result written into a full queue");

	// The fill level stays within the queue depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mbsp_pkg::OQ_CW'(mbsp_pkg::OQ_DEPTH))
		else $error("result queue count out of range");

	// A write with no read raises the fill level by one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> (count_q == $past(count_q) + 1'b1))
		else $error("result queue count did not advance");
`endif

endmodule

>>> sv/midi_byte_stream_parser.sv
// Bytes go into the front queue; the engine decodes the head and writes results to the result queue.
// Throughput: one byte per cycle while the result queue has room; an F0 in a sysex gives two results.
// The rate is set by the single result write port of the parse engine into the result queue.
// Reset (arst_n low) empties both queues, clears the running status and idles the parser.
// ----------------------------------------------------------------------------
// MIDI byte stream parser
// Decodes a received MIDI byte stream with running status into messages.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  msg_kind,
	output logic [3:0]  channel,
	output logic [6:0]  first_data,
	output logic [6:0]  second_data,
	output logic [13:0] combined_value,
	output logic        last_of_run
);

	mbsp_pkg::cls_item_t head;
	logic                head_valid;
	logic                head_pop;
	mbsp_pkg::result_t   res;
	logic                res_push;
	logic                res_full;
	mbsp_pkg::result_t   out_res;

	mbsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.rx_byte    (rx_byte),
		.full       (full),
		.head_pop   (head_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	mbsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res)
	);

	mbsp_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_push  (res_push),
		.wr_data  (res),
		.wr_full  (res_full),
		.rd_pop   (pop),
		.rd_empty (empty),
		.rd_data  (out_res)
	);

	assign msg_kind       = out_res.kind;
	assign channel        = out_res.channel;
	assign first_data     = out_res.first_data;
	assign second_data    = out_res.second_data;
	assign combined_value = {out_res.second_data, out_res.first_data};
	assign last_of_run    = out_res.last;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI byte stream parser testbench
// Sends directed and random byte streams through the parser, predicts every
// decoded message with a behavioral parser, and checks each result transfer
// against the oldest prediction, with random send idles and receive stalls in some phases.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CLK_PERIOD     = 20;
	localparam int RESET_CYCLES   = 10;
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_BYTES    = 240;
	localparam int MAX_REPORTS    = 10;

	localparam logic [7:0] STATUS_SYSTEM   = 8'hF0;
	localparam logic [7:0] STATUS_SX_START = 8'hF0;
	localparam logic [7:0] STATUS_QFRAME   = 8'hF1;
	localparam logic [7:0] STATUS_SONGPOS  = 8'hF2;
	localparam logic [7:0] STATUS_SONGSEL  = 8'hF3;
	localparam logic [7:0] STATUS_COMMON_LAST = 8'hF6;
	localparam logic [7:0] STATUS_SX_END   = 8'hF7;
	localparam logic [7:0] STATUS_REALTIME = 8'hF8;
	localparam logic [7:0] STATUS_VOICE    = 8'h80;

	typedef enum logic [2:0] {
		PS_IDLE,
		PS_ONE,
		PS_FIRST,
		PS_SECOND,
		PS_SYSEX
	} parse_phase_t;

	typedef struct packed {
		mbsp_pkg::msg_kind_t kind;
		logic [3:0]          channel;
		logic [6:0]          first_data;
		logic [6:0]          second_data;
		logic [13:0]         combined;
		logic                last;
	} midi_msg_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  rx_byte = 8'h00;
	logic        empty;
	logic        pop = 1'b0;
	logic [3:0]  msg_kind;
	logic [3:0]  channel;
	logic [6:0]  first_data;
	logic [6:0]  second_data;
	logic [13:0] combined_value;
	logic        last_of_run;

	logic [7:0] pending_bytes[$];
	midi_msg_t  expected_msgs[$];
	midi_msg_t  want_msg;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         phase_bytes = 0;
	int         error_count = 0;
	int         idle_cycles = 0;

	parse_phase_t        parse_phase = PS_IDLE;
	logic [7:0]          running_status_q = 8'h00;
	mbsp_pkg::msg_kind_t assembling_kind = mbsp_pkg::K_NOTEOFF;
	logic [6:0]          held_data1 = 7'd0;

	midi_byte_stream_parser i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.rx_byte        (rx_byte),
		.empty          (empty),
		.pop            (pop),
		.msg_kind       (msg_kind),
		.channel        (channel),
		.first_data     (first_data),
		.second_data    (second_data),
		.combined_value (combined_value),
		.last_of_run    (last_of_run)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic void push_decoded(mbsp_pkg::msg_kind_t kind, logic [3:0] chan,
			logic [6:0] d1, logic [6:0] d2);
		midi_msg_t m;
		m.kind        = kind;
		m.channel     = chan;
		m.first_data  = d1;
		m.second_data = d2;
		m.combined    = {d2, d1};
		m.last        = 1'b0;
		expected_msgs.push_back(m);
	endfunction

	function automatic void predict_byte(logic [7:0] b);
		int                  n_before;
		int                  last_idx;
		logic [3:0]          chan;
		mbsp_pkg::msg_kind_t kind;
		n_before = expected_msgs.size();
		chan = (running_status_q >= STATUS_VOICE && running_status_q < STATUS_SYSTEM) ?
			running_status_q[3:0] : 4'd0;
		if (b[7]) begin
			if (b < STATUS_REALTIME) begin
				if (parse_phase == PS_SYSEX) begin
					push_decoded(mbsp_pkg::K_SXEND, 4'd0, 7'd0, 7'd0);
					parse_phase = PS_IDLE;
				end
				if (b < STATUS_SYSTEM) begin
					running_status_q = b;
					assembling_kind = mbsp_pkg::msg_kind_t'({1'b0, b[6:4]});
					parse_phase = (assembling_kind == mbsp_pkg::K_PROG ||
						assembling_kind == mbsp_pkg::K_CHANAT) ? PS_ONE : PS_FIRST;
				end else begin
					running_status_q = 8'h00;
					case (b)
						STATUS_SX_START: begin
							push_decoded(mbsp_pkg::K_SXSTART, 4'd0, 7'd0, 7'd0);
							parse_phase = PS_SYSEX;
						end
						STATUS_QFRAME: begin
							assembling_kind = mbsp_pkg::K_QFRAME;
							parse_phase = PS_ONE;
						end
						STATUS_SONGPOS: begin
							assembling_kind = mbsp_pkg::K_SONGPOS;
							parse_phase = PS_FIRST;
						end
						STATUS_SONGSEL: begin
							assembling_kind = mbsp_pkg::K_SONGSEL;
							parse_phase = PS_ONE;
						end
						default: parse_phase = PS_IDLE;
					endcase
				end
			end
		end else begin
			case (parse_phase)
				PS_ONE: begin
					push_decoded(assembling_kind, chan, b[6:0], 7'd0);
					parse_phase = (running_status_q != 8'h00) ? PS_ONE : PS_IDLE;
				end
				PS_FIRST: begin
					held_data1 = b[6:0];
					parse_phase = PS_SECOND;
				end
				PS_SECOND: begin
					parse_phase = (running_status_q != 8'h00) ? PS_FIRST : PS_IDLE;
					if (!(assembling_kind == mbsp_pkg::K_CC &&
							held_data1 >= mbsp_pkg::CC_MODE_MIN)) begin
						kind = (assembling_kind == mbsp_pkg::K_NOTEON && b[6:0] == 7'd0) ?
							mbsp_pkg::K_NOTEOFF : assembling_kind;
						push_decoded(kind, chan, held_data1, b[6:0]);
					end
				end
				PS_SYSEX: push_decoded(mbsp_pkg::K_SXDATA, 4'd0, b[6:0], 7'd0);
				default: parse_phase = PS_IDLE;
			endcase
		end
		if (expected_msgs.size() > n_before) begin
			last_idx = expected_msgs.size() - 1;
			expected_msgs[last_idx].last = 1'b1;
		end
	endfunction

	function automatic void flag_error(string msg);
		if (error_count < MAX_REPORTS)
			$display("ERROR at %0t: %s", $realtime, msg);
		error_count++;
	endfunction

	function automatic string msg_text(logic [3:0] kind, logic [3:0] chan, logic [6:0] d1,
			logic [6:0] d2, logic [13:0] comb, logic last);
		return $sformatf("kind=%0d ch=%0d d1=%0d d2=%0d comb=%0d last=%0b",
			kind, chan, d1, d2, comb, last);
	endfunction

	// Byte transfers are predicted at the edge that accepts them.
	always @(posedge clk) begin
		if (!arst_n) begin
			push    <= 1'b0;
			rx_byte <= 8'h00;
		end else begin
			if (push && !full) begin
				predict_byte(rx_byte);
				void'(pending_bytes.pop_front());
			end
			if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				push    <= 1'b1;
				rx_byte <= pending_bytes[0];
			end else begin
				push    <= 1'b0;
				rx_byte <= 8'($urandom_range(255));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_msgs.size() == 0) begin
					flag_error({"unexpected result ", msg_text(msg_kind, channel, first_data,
						second_data, combined_value, last_of_run)});
				end else begin
					want_msg = expected_msgs.pop_front();
					if (msg_kind !== want_msg.kind || channel !== want_msg.channel ||
							first_data !== want_msg.first_data ||
							second_data !== want_msg.second_data ||
							combined_value !== want_msg.combined ||
							last_of_run !== want_msg.last)
						flag_error({"expected ", msg_text(want_msg.kind, want_msg.channel,
							want_msg.first_data, want_msg.second_data, want_msg.combined,
							want_msg.last), " actual ", msg_text(msg_kind, channel,
							first_data, second_data, combined_value, last_of_run)});
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic void add_byte(logic [7:0] b);
		pending_bytes.push_back(b);
		if (b < STATUS_REALTIME)
			phase_bytes++;
	endfunction

	function automatic logic [6:0] pick_data();
		case ($urandom_range(7))
			0: return 7'd0;
			1: return 7'd127;
			2: return 7'($urandom_range(127, 118));
			default: return 7'($urandom_range(127));
		endcase
	endfunction

	function automatic void maybe_realtime();
		if ($urandom_range(15) == 0)
			add_byte(8'($urandom_range(8'hFF, STATUS_REALTIME)));
	endfunction

	function automatic logic [7:0] pick_voice_status();
		logic [7:0] status;
		status      = STATUS_VOICE;
		status[6:4] = 3'($urandom_range(6));
		status[3:0] = 4'($urandom_range(15));
		return status;
	endfunction

	// Most traffic is well-formed messages with running status; the rest is
	// system common, sysex, truncated messages and raw noise.
	function automatic void queue_random_message();
		int         sel;
		int         reps;
		int         n_data;
		logic [7:0] status;
		sel = $urandom_range(99);
		if (sel < 55) begin
			status = pick_voice_status();
			n_data = (status[6:4] == 3'd4 || status[6:4] == 3'd5) ? 1 : 2;
			add_byte(status);
			reps = $urandom_range(3);
			repeat (reps + 1) begin
				for (int i = 0; i < n_data; i++) begin
					maybe_realtime();
					add_byte({1'b0, pick_data()});
				end
			end
		end else if (sel < 67) begin
			status = STATUS_QFRAME + 8'($urandom_range(2));
			add_byte(status);
			n_data = (status == STATUS_SONGPOS) ? 2 : 1;
			for (int i = 0; i < n_data; i++)
				add_byte({1'b0, pick_data()});
			if ($urandom_range(3) == 0)
				add_byte({1'b0, pick_data()});
		end else if (sel < 82) begin
			add_byte(STATUS_SX_START);
			reps = $urandom_range(5);
			for (int i = 0; i < reps; i++) begin
				maybe_realtime();
				add_byte({1'b0, pick_data()});
			end
			case ($urandom_range(5))
				0: add_byte(STATUS_SX_START);
				1: add_byte(8'($urandom_range(STATUS_COMMON_LAST, STATUS_VOICE)));
				default: add_byte(STATUS_SX_END);
			endcase
		end else if (sel < 91) begin
			add_byte(pick_voice_status());
			if ($urandom_range(1) == 1)
				add_byte({1'b0, pick_data()});
			add_byte(8'($urandom_range(STATUS_SX_END, STATUS_VOICE)));
		end else begin
			add_byte(8'($urandom_range(255)));
		end
	endfunction

	task automatic wait_for_drain();
		while (pending_bytes.size() != 0 || push || expected_msgs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [7:0] directed_bytes[$];
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Note on with zero velocity, control changes on both sides of 120,
		// every channel kind, system common, and a sysex cut short by F0 and
		// by a system common status.
		directed_bytes = '{8'h90, 8'h3C, 8'h00, 8'h7F, 8'h7F,
			8'hB1, 8'h78, 8'h01, 8'h77, 8'h7F,
			8'hA2, 8'h00, 8'h7F, 8'hC3, 8'h06, 8'hD4, 8'h7F, 8'hE5, 8'h7F, 8'h7F,
			8'hF1, 8'h20, 8'hF2, 8'h00, 8'h40,
			8'hF0, 8'h7F, 8'hF0, 8'hF3, 8'h05};
		foreach (directed_bytes[i])
			add_byte(directed_bytes[i]);
		wait_for_drain();

		for (int phase = 0; phase < 4; phase++) begin
			@(negedge clk);
			send_idle_pct  = (phase == 1) ? 56 : (phase == 3) ? 31 : 0;
			recv_stall_pct = (phase == 2) ? 56 : (phase == 3) ? 31 : 0;
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES)
				queue_random_message();
			wait_for_drain();
		end

		if (expected_msgs.size() != 0)
			flag_error($sformatf("%0d results never arrived", expected_msgs.size()));
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> midi_byte_stream_parser.f
sv/mbsp_pkg.sv
sv/mbsp_front.sv
sv/mbsp_back.sv
sv/mbsp_outq.sv
sv/midi_byte_stream_parser.sv
test/tb_top.sv
